>>> hw/rtl/tle_pkg.sv
// Shared types, constants and helpers for the terminal line editor.
// No dependencies; terminal_line_editor and tle_edit_ctrl refer to this package.
package tle_pkg;

	localparam int unsigned LineCapacityDefault = 256;

	localparam logic [7:0] NewlineChar = 8'h0A;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_END        = 2'd0,
		REG_WORD_ERASE = 2'd1,
		REG_ERASE      = 2'd2,
		REG_KILL       = 2'd3
	} reg_index_t;

	localparam logic [7:0] EndCharReset       = 8'd4;
	localparam logic [7:0] WordEraseCharReset = 8'd23;
	localparam logic [7:0] EraseCharReset     = 8'd127;
	localparam logic [7:0] KillCharReset      = 8'd21;

	typedef enum logic [2:0] {
		KIND_ECHO    = 3'd0,
		KIND_ERASE   = 3'd1,
		KIND_BELL    = 3'd2,
		KIND_ENDED   = 3'd3,
		KIND_IGNORED = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_WALK,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] end_char;
		logic [7:0] word_erase_char;
		logic [7:0] erase_char;
		logic [7:0] kill_char;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] echo_char;
		logic [8:0] erased_count;
		logic [8:0] line_length;
	} result_t;

	function automatic logic is_white(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

endpackage

>>> hw/rtl/terminal_line_editor.sv
// Terminal line editor top level: configuration registers, editing sequencer
// and output register. Uses tle_pkg and tle_edit_ctrl.
//
// Each request carries one typed byte and yields exactly one response. A byte
// that is stored, erases a single character, rings the bell or concerns the
// end of the session passes through the classify and emit states before its
// response is parked in the output register, and the next byte is accepted
// once the sequencer is back in idle. Erase requests for a word or back to the
// last newline walk the line buffer backwards through its single read port,
// alternating walk and check states for each character examined. A new byte
// is taken while the previous response still waits in the output register.
// The line buffer holds no reset value; only characters already typed are
// ever read.
module terminal_line_editor #(
	parameter int unsigned LINE_CAPACITY = tle_pkg::LineCapacityDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] response_kind,
	output logic [7:0] echo_char,
	output logic [8:0] erased_count,
	output logic [8:0] line_length
);

	tle_pkg::cfg_t    cfg_q;
	tle_pkg::result_t res;
	tle_pkg::result_t out_q;
	logic             res_valid;
	logic             res_take;
	logic             out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_char        <= tle_pkg::EndCharReset;
			cfg_q.word_erase_char <= tle_pkg::WordEraseCharReset;
			cfg_q.erase_char      <= tle_pkg::EraseCharReset;
			cfg_q.kill_char       <= tle_pkg::KillCharReset;
		end else if (cfg_valid) begin
			case (tle_pkg::reg_index_t'(cfg_index))
				tle_pkg::REG_END:        cfg_q.end_char        <= cfg_data;
				tle_pkg::REG_WORD_ERASE: cfg_q.word_erase_char <= cfg_data;
				tle_pkg::REG_ERASE:      cfg_q.erase_char      <= cfg_data;
				tle_pkg::REG_KILL:       cfg_q.kill_char       <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	tle_edit_ctrl #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_edit_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// The output register frees the sequencer as soon as a response is parked.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign response_kind = out_q.kind;
	assign echo_char     = out_q.echo_char;
	assign erased_count  = out_q.erased_count;
	assign line_length   = out_q.line_length;

endmodule

>>> hw/rtl/tle_line_mem.sv
// Line buffer storage: one write port, one read port, registered read data.
// Depends on nothing but its parameter.
module tle_line_mem #(
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tle_edit_ctrl.sv
// Editing sequencer: classifies each byte, appends to the line buffer and
// walks it backwards for word and kill erase requests. Uses tle_pkg and tle_line_mem.
module tle_edit_ctrl #(
	parameter int unsigned LINE_CAPACITY = tle_pkg::LineCapacityDefault,
	localparam int unsigned AW = $clog2(LINE_CAPACITY),
	localparam int unsigned CW = $clog2(LINE_CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tle_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	output logic              res_valid,
	input  logic              res_take,
	output tle_pkg::result_t  res
);

	tle_pkg::state_t state_q, state_d;
	tle_pkg::kind_t  kind_q, kind_d;
	logic [7:0]      byte_q, byte_d;
	logic [7:0]      echo_q, echo_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   start_q, start_d;
	logic            kill_q, kill_d;
	logic            white_q, white_d;
	logic            ended_q, ended_d;

	logic            walk_go;
	logic            append_ok;
	logic            mem_we;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [7:0]      mem_rdata;
	logic [CW-1:0]   erased;
	logic [CW+8:0]   erased_ext;
	logic [CW+8:0]   length_ext;

	// While skipping trailing white space one character must stay behind.
	assign walk_go = (!kill_q && white_q) ? (count_q > CW'(1)) : (count_q != '0);

	assign append_ok = (byte_q == tle_pkg::NewlineChar || byte_q inside {[8'h20:8'h7E]})
		&& (count_q != CW'(LINE_CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tle_pkg::ST_IDLE;
			count_q <= '0;
			ended_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ended_q <= ended_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		byte_q  <= byte_d;
		echo_q  <= echo_d;
		start_q <= start_d;
		kill_q  <= kill_d;
		white_q <= white_d;
	end

	// Next state and register updates.
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		byte_d  = byte_q;
		echo_d  = echo_q;
		count_d = count_q;
		start_d = start_q;
		kill_d  = kill_q;
		white_d = white_q;
		ended_d = ended_q;
		case (state_q)
			tle_pkg::ST_IDLE: begin
				if (in_valid) begin
					byte_d  = in_byte;
					state_d = tle_pkg::ST_CLASSIFY;
				end
			end
			tle_pkg::ST_CLASSIFY: begin
				start_d = count_q;
				echo_d  = 8'h00;
				kind_d  = tle_pkg::KIND_BELL;
				state_d = tle_pkg::ST_EMIT;
				if (ended_q) begin
					kind_d = tle_pkg::KIND_IGNORED;
				end else if (byte_q == cfg.end_char) begin
					ended_d = 1'b1;
					kind_d  = tle_pkg::KIND_ENDED;
				end else if (byte_q == cfg.word_erase_char) begin
					kind_d  = tle_pkg::KIND_ERASE;
					kill_d  = 1'b0;
					white_d = 1'b1;
					state_d = tle_pkg::ST_WALK;
				end else if (byte_q == cfg.erase_char) begin
					kind_d = tle_pkg::KIND_ERASE;
					if (count_q != '0) begin
						count_d = count_q - CW'(1);
					end
				end else if (byte_q == cfg.kill_char) begin
					kind_d  = tle_pkg::KIND_ERASE;
					kill_d  = 1'b1;
					white_d = 1'b0;
					state_d = tle_pkg::ST_WALK;
				end else if (append_ok) begin
					kind_d  = tle_pkg::KIND_ECHO;
					echo_d  = byte_q;
					count_d = count_q + CW'(1);
				end
			end
			tle_pkg::ST_WALK: begin
				if (walk_go) begin
					state_d = tle_pkg::ST_CHECK;
				end else if (!kill_q && white_q) begin
					white_d = 1'b0;
				end else begin
					state_d = tle_pkg::ST_EMIT;
				end
			end
			tle_pkg::ST_CHECK: begin
				state_d = tle_pkg::ST_WALK;
				if (kill_q) begin
					if (mem_rdata != tle_pkg::NewlineChar) begin
						count_d = count_q - CW'(1);
					end else begin
						state_d = tle_pkg::ST_EMIT;
					end
				end else if (white_q) begin
					// The first non-blank character starts the word itself.
					count_d = count_q - CW'(1);
					if (!tle_pkg::is_white(mem_rdata)) begin
						white_d = 1'b0;
					end
				end else if (!tle_pkg::is_white(mem_rdata)) begin
					count_d = count_q - CW'(1);
				end else begin
					state_d = tle_pkg::ST_EMIT;
				end
			end
			tle_pkg::ST_EMIT: begin
				if (res_take) begin
					state_d = tle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tle_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			tle_pkg::ST_IDLE:     in_ready  = 1'b1;
			tle_pkg::ST_CLASSIFY: mem_we    = !ended_q && (byte_q != cfg.end_char)
				&& (byte_q != cfg.word_erase_char) && (byte_q != cfg.erase_char)
				&& (byte_q != cfg.kill_char) && append_ok;
			tle_pkg::ST_WALK:     mem_re    = walk_go;
			tle_pkg::ST_EMIT:     res_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign mem_raddr = AW'(count_q - CW'(1));

	assign erased     = (kind_q == tle_pkg::KIND_ERASE) ? (start_q - count_q) : '0;
	assign erased_ext = {9'd0, erased};
	assign length_ext = {9'd0, count_q};

	assign res.kind         = kind_q;
	assign res.echo_char    = echo_q;
	assign res.erased_count = erased_ext[8:0];
	assign res.line_length  = length_ext[8:0];

	tle_line_mem #(
		.DEPTH(LINE_CAPACITY)
	) u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (byte_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
